// ===== src/tcce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_pkg : shared definitions for the text console cursor engine
// Field widths, request codes, character codes and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcce_pkg;

	// default geometry
	localparam int DEF_COLUMNS = 80;
	localparam int DEF_CELLS   = 2000;

	// field widths
	localparam int FUNC_W = 2;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int IDX_W  = 11;
	localparam int CELL_W = 16;
	localparam int POS_W  = 11;

	// request codes
	localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	// character codes with a meaning of their own
	localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
	localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;

	// blank attribute after reset and the blank cell it gives
	localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'd7;
	localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, CHAR_SPACE};

	// controller to datapath
	typedef struct packed {
		logic load_req;   // capture the request fields
		logic rd_req;     // read the cell named by the request
		logic put;        // apply a put character step
		logic scroll_adj; // pull the cursor back one row
		logic copy;       // one step of the scroll copy
		logic fill;       // write one blank cell
		logic fill_rst;   // blank with the reset attribute
		logic cur_home;   // home the cursor
		logic cnt_clr;    // restart the sweep counter
		logic load_out;   // load the result register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_scroll; // put moves the cursor past the last cell
		logic copy_last;   // scroll copy is at its final step
		logic fill_last;   // fill is at the last cell
	} sts_t;

endpackage

// ===== src/tcce_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_dp : datapath of the text console cursor engine
// Screen buffer memory, cursor and column registers, sweep counter for scroll
// and clear, blank attribute register and the result register.
// ----------------------------------------------------------------------------
module tcce_dp
	import tcce_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int CELLS   = DEF_CELLS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [FUNC_W-1:0] func,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [ATTR_W-1:0] attribute,
	input  logic [IDX_W-1:0]  cell_index,
	input  logic              cfg_we,
	input  logic [ATTR_W-1:0] cfg_wdata,
	output logic [CELL_W-1:0] cell_value,
	output logic [POS_W-1:0]  cursor_position
);

	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(CELLS + COLUMNS);
	localparam int COLW  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int SHIFT = (COLUMNS < CELLS) ? COLUMNS : CELLS;
	localparam int KEEP  = CELLS - SHIFT;

	logic [FUNC_W-1:0] func_q;
	logic [CHAR_W-1:0] char_q;
	logic [ATTR_W-1:0] attr_q;
	logic [IDX_W-1:0]  idx_q;
	logic [ATTR_W-1:0] blank_attr_q;
	logic [CW-1:0]     cur_q;
	logic [COLW-1:0]   col_q;
	logic [AW-1:0]     cnt_q;
	logic [CELL_W-1:0] rdata_q;
	logic [CELL_W-1:0] cell_value_q;
	logic [POS_W-1:0]  cursor_position_q;
	logic [CELL_W-1:0] screen_mem [CELLS];

	logic [CW-1:0]     cur_put;
	logic [COLW-1:0]   col_put;
	logic              put_wr;
	logic [CW-1:0]     col_ext;
	logic              copy_last;
	logic              fill_last;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [CELL_W-1:0] mem_wd;
	logic              mem_re;
	logic [AW-1:0]     mem_ra;
	logic              idx_ok;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			func_q <= func;
			char_q <= char_code;
			attr_q <= attribute;
			idx_q  <= cell_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_attr_q <= RESET_ATTR;
		end else if (cfg_we) begin
			blank_attr_q <= cfg_wdata;
		end
	end

	// put step: the column register stands in for cursor modulo row width
	assign col_ext = CW'(col_q);

	always_comb begin
		cur_put = cur_q;
		col_put = col_q;
		put_wr  = 1'b0;
		case (char_q)
			CHAR_CR: begin
				cur_put = cur_q - col_ext;
				col_put = '0;
			end
			CHAR_LF: begin
				cur_put = cur_q - col_ext + CW'(COLUMNS);
				col_put = '0;
			end
			CHAR_BS: begin
				if (col_q != '0) begin
					cur_put = cur_q - CW'(1);
					col_put = col_q - COLW'(1);
				end
			end
			default: begin
				put_wr  = 1'b1;
				cur_put = cur_q + CW'(1);
				col_put = (col_q == COLW'(COLUMNS - 1)) ? '0 : col_q + COLW'(1);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			col_q <= '0;
		end else if (cmd.cur_home) begin
			cur_q <= '0;
			col_q <= '0;
		end else if (cmd.put) begin
			cur_q <= cur_put;
			col_q <= col_put;
		end else if (cmd.scroll_adj) begin
			if (cur_q >= CW'(COLUMNS)) begin
				cur_q <= cur_q - CW'(COLUMNS);
			end else begin
				cur_q <= '0;
				col_q <= '0;
			end
		end
	end

	// sweep counter: copy index first, then fill address
	assign copy_last = (cnt_q == AW'(KEEP));
	assign fill_last = (cnt_q == AW'(CELLS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if ((cmd.copy && !copy_last) || (cmd.fill && !fill_last)) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	// memory ports: the copy writes each registered read back one row above the cell it was read from
	always_comb begin
		mem_we = 1'b0;
		mem_wa = AW'(cur_q);
		mem_wd = {attr_q, char_q};
		if (cmd.put && put_wr) begin
			mem_we = 1'b1;
		end else if (cmd.copy && cnt_q != '0) begin
			mem_we = 1'b1;
			mem_wa = cnt_q - AW'(1);
			mem_wd = rdata_q;
		end else if (cmd.fill) begin
			mem_we = 1'b1;
			mem_wa = cnt_q;
			mem_wd = cmd.fill_rst ? RESET_BLANK : {blank_attr_q, CHAR_SPACE};
		end
	end

	assign mem_re = cmd.rd_req || (cmd.copy && !copy_last);
	assign mem_ra = cmd.rd_req ? AW'(cell_index) : cnt_q + AW'(SHIFT);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			screen_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= screen_mem[mem_ra];
		end
	end

	// result register
	assign idx_ok = (32'(idx_q) < 32'(CELLS));

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			cell_value_q      <= (func_q == FUNC_READ && idx_ok) ? rdata_q : '0;
			cursor_position_q <= POS_W'(cur_q);
		end
	end

	assign cell_value      = cell_value_q;
	assign cursor_position = cursor_position_q;

	assign sts.need_scroll = (32'(cur_put) >= 32'(CELLS));
	assign sts.copy_last   = copy_last;
	assign sts.fill_last   = fill_last;

`ifndef NO_ASSERTIONS
	a_put_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |-> (32'(cur_q) < 32'(CELLS)))
		else $error("cursor beyond the screen at a put step");

	a_scroll_fixes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scroll_adj |=> (32'(cur_q) < 32'(CELLS)))
		else $error("cursor still beyond the screen after scroll");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < 32'(COLUMNS))
		else $error("column register out of range");
`endif

endmodule

// ===== src/tcce_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_ctrl : controller of the text console cursor engine
// Sequences the reset fill, put, read, scroll and clear requests and owns the
// request and result handshakes.
// ----------------------------------------------------------------------------
module tcce_ctrl
	import tcce_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [FUNC_W-1:0] func,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  sts_t              sts,
	output cmd_t              cmd
);

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_PUT   = 3'd2;
	localparam logic [2:0] ST_SADJ  = 3'd3;
	localparam logic [2:0] ST_SCOPY = 3'd4;
	localparam logic [2:0] ST_FILL  = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd.fill     = 1'b1;
				cmd.fill_rst = 1'b1;
				if (sts.fill_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					unique case (func)
						FUNC_PUT: state_d = ST_PUT;
						FUNC_READ: begin
							cmd.rd_req = 1'b1;
							state_d    = ST_DONE;
						end
						FUNC_CLEAR: begin
							cmd.cur_home = 1'b1;
							cmd.cnt_clr  = 1'b1;
							state_d      = ST_FILL;
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_PUT: begin
				cmd.put = 1'b1;
				state_d = sts.need_scroll ? ST_SADJ : ST_DONE;
			end
			ST_SADJ: begin
				cmd.scroll_adj = 1'b1;
				cmd.cnt_clr    = 1'b1;
				state_d        = ST_SCOPY;
			end
			ST_SCOPY: begin
				cmd.copy = 1'b1;
				if (sts.copy_last) state_d = ST_FILL;
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				if (sts.fill_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second request taken while one is in flight");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside the completion state");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before it was taken");
`endif

endmodule

// ===== src/text_console_cursor_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit : character-cell text console
// Screen buffer of CELLS 16-bit cells in rows of COLUMNS, with a cursor.
// Puts characters (CR, LF, backspace, printable), scrolls, clears and reads
// back single cells. One result per request.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  request  | in_valid / in_ready  | func, char_code, attribute, cell_index
//  result   | out_valid / out_ready| cell_value, cursor_position
//  config   | cfg_we               | cfg_wdata (blank attribute)
//
// Request completion: a read or unused code finishes soonest, a put moves the
//   cursor, a clear blanks every cell and a put that scrolls copies the rows
//   up and blanks the last one. The single write port of the screen memory
//   moves or blanks one cell per cycle during scroll and clear.
// Reset: a fill pass blanks the buffer; in_ready stays low.
// Stalls: a finished result waits in its register while the next request is
//   taken; only the completion of that next request waits on out_ready.
module text_console_cursor_engine_unit
	import tcce_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int CELLS   = DEF_CELLS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [FUNC_W-1:0] func,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [ATTR_W-1:0] attribute,
	input  logic [IDX_W-1:0]  cell_index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CELL_W-1:0] cell_value,
	output logic [POS_W-1:0]  cursor_position,
	input  logic              cfg_we,
	input  logic [ATTR_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	// sequencing: reset fill, put, scroll copy and blank, clear, read
	tcce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.func      (func),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// buffer memory, cursor, sweep counter and result register
	tcce_dp #(
		.COLUMNS (COLUMNS),
		.CELLS   (CELLS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.func            (func),
		.char_code       (char_code),
		.attribute       (attribute),
		.cell_index      (cell_index),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.cell_value      (cell_value),
		.cursor_position (cursor_position)
	);

endmodule

// ===== tb/console_screen_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_screen_checker : screen and cursor predictor for the text console
// Keeps its own copy of the screen cells, the cursor and the blank attribute.
// Works out the result of every request that is taken and compares each
// delivered result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module console_screen_checker
	import tcce_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int CELLS   = DEF_CELLS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [FUNC_W-1:0] func,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [ATTR_W-1:0] attribute,
	input  logic [IDX_W-1:0]  cell_index,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [CELL_W-1:0] cell_value,
	input  logic [POS_W-1:0]  cursor_position,
	input  logic              cfg_we,
	input  logic [ATTR_W-1:0] cfg_wdata,
	output int unsigned       failures,
	output int unsigned       pending,
	output int unsigned       requests_seen,
	output int unsigned       reads_seen,
	output int unsigned       scrolls_seen,
	output logic [POS_W-1:0]  cursor_now
);

	localparam int unsigned PRINT_LIMIT = 40;

	typedef struct packed {
		logic [CELL_W-1:0] cell_val;
		logic [POS_W-1:0]  pos;
	} console_out_t;

	logic [CELL_W-1:0] screen [CELLS];
	int unsigned       cursor;
	logic [ATTR_W-1:0] blank_attr;
	console_out_t      predicted_outputs [$];

	int unsigned mismatches = 0;
	int unsigned n_requests = 0;
	int unsigned n_reads    = 0;
	int unsigned n_scrolls  = 0;

	function automatic logic [CELL_W-1:0] blank_cell();
		return {blank_attr, CHAR_SPACE};
	endfunction

	function automatic void blank_screen();
		int unsigned i;
		for (i = 0; i < CELLS; i++)
			screen[i] = blank_cell();
		cursor = 0;
	endfunction

	// move every row up by one and blank the last row's worth of cells
	function automatic void scroll_screen();
		int unsigned shift;
		int unsigned keep;
		int unsigned i;
		shift = (COLUMNS < CELLS) ? COLUMNS : CELLS;
		keep  = CELLS - shift;
		for (i = 0; i < keep; i++)
			screen[i] = screen[i + shift];
		for (i = keep; i < CELLS; i++)
			screen[i] = blank_cell();
		cursor = (cursor >= COLUMNS) ? cursor - COLUMNS : 0;
		n_scrolls++;
	endfunction

	function automatic void put_character(logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] at);
		int unsigned col;
		col = cursor % COLUMNS;
		if (ch == CHAR_CR) begin
			cursor = cursor - col;
		end else if (ch == CHAR_LF) begin
			cursor = cursor - col + COLUMNS;
		end else if (ch == CHAR_BS) begin
			if (col != 0)
				cursor = cursor - 1;
		end else begin
			if (cursor < CELLS)
				screen[cursor] = {at, ch};
			cursor = cursor + 1;
		end
		if (cursor >= CELLS)
			scroll_screen();
	endfunction

	function automatic console_out_t apply_request(logic [FUNC_W-1:0] f,
			logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] at, logic [IDX_W-1:0] idx);
		console_out_t res;
		res.cell_val = '0;
		case (f)
			FUNC_PUT: begin
				put_character(ch, at);
			end
			FUNC_READ: begin
				if (idx < CELLS)
					res.cell_val = screen[idx];
			end
			FUNC_CLEAR: begin
				blank_screen();
			end
			default: begin
			end
		endcase
		res.pos = POS_W'(cursor);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t ns  %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		console_out_t want;
		if (!arst_n) begin
			blank_attr = RESET_ATTR;
			blank_screen();
			predicted_outputs.delete();
		end else begin
			if (cfg_we)
				blank_attr = cfg_wdata;
			if (in_valid && in_ready) begin
				predicted_outputs.push_back(apply_request(func, char_code, attribute,
					cell_index));
				n_requests++;
				if (func == FUNC_READ)
					n_reads++;
			end
			if (out_valid && out_ready) begin
				if (predicted_outputs.size() == 0) begin
					report_mismatch("result with no request outstanding",
						32'({cell_value, cursor_position}), '0);
				end else begin
					want = predicted_outputs.pop_front();
					if (cell_value !== want.cell_val)
						report_mismatch("cell_value", 32'(cell_value),
							32'(want.cell_val));
					if (cursor_position !== want.pos)
						report_mismatch("cursor_position", 32'(cursor_position),
							32'(want.pos));
				end
			end
		end
		failures      <= mismatches;
		pending       <= predicted_outputs.size();
		requests_seen <= n_requests;
		reads_seen    <= n_reads;
		scrolls_seen  <= n_scrolls;
		cursor_now    <= POS_W'(cursor);
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench : request traffic for the text console cursor engine
// Drives put, read, clear and unused requests through the request channel,
// throttles the result channel, and steps the blank attribute through its
// reset value, both extremes and random values between phases. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import tcce_pkg::*;

	localparam int          CLK_PERIOD     = 4;
	localparam int          RESET_CYCLES   = 5;
	localparam int unsigned WATCHDOG_LIMIT = 20000; // well above a scroll plus a long hold
	localparam int unsigned LONG_HOLD      = 600;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned PHASE_ITEMS    = 70;
	localparam int unsigned TAIL_CYCLES    = 20;

	// the one code the block leaves unused
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [FUNC_W-1:0] func;
	logic [CHAR_W-1:0] char_code;
	logic [ATTR_W-1:0] attribute;
	logic [IDX_W-1:0]  cell_index;
	logic              out_valid;
	logic              out_ready;
	logic [CELL_W-1:0] cell_value;
	logic [POS_W-1:0]  cursor_position;
	logic              cfg_we;
	logic [ATTR_W-1:0] cfg_wdata;

	int unsigned      failures;
	int unsigned      pending;
	int unsigned      requests_seen;
	int unsigned      reads_seen;
	int unsigned      scrolls_seen;
	logic [POS_W-1:0] cursor_now;

	// throttle knobs, changed per phase
	int unsigned sender_gap_pct = 0;
	int unsigned sink_stall_pct = 0;
	bit          hold_results   = 1'b0;
	int unsigned requests_sent  = 0;
	int unsigned quiet_cycles   = 0;

	text_console_cursor_engine_unit #(
		.COLUMNS(DEF_COLUMNS),
		.CELLS  (DEF_CELLS)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.char_code      (char_code),
		.attribute      (attribute),
		.cell_index     (cell_index),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.cell_value     (cell_value),
		.cursor_position(cursor_position),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata)
	);

	console_screen_checker #(
		.COLUMNS(DEF_COLUMNS),
		.CELLS  (DEF_CELLS)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.char_code      (char_code),
		.attribute      (attribute),
		.cell_index     (cell_index),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.cell_value     (cell_value),
		.cursor_position(cursor_position),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.failures       (failures),
		.pending        (pending),
		.requests_seen  (requests_seen),
		.reads_seen     (reads_seen),
		.scrolls_seen   (scrolls_seen),
		.cursor_now     (cursor_now)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Idle stretch length, drawn from three weighted ranges; now and then a long one.
	function automatic int unsigned idle_length();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			return $urandom_range(1, 3);
		else if (roll < 95)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 80);
	endfunction

	// Any byte except the three control codes; those get their own sequences.
	function automatic logic [CHAR_W-1:0] printable_char();
		logic [CHAR_W-1:0] ch;
		ch = CHAR_W'($urandom_range(0, 255));
		if (ch == CHAR_CR || ch == CHAR_LF || ch == CHAR_BS)
			ch = ch ^ 8'h40;
		return ch;
	endfunction

	// Cell index for a read: mostly just behind the cursor, where recent
	// writes and scrolled rows sit, otherwise anywhere including past the end.
	function automatic logic [IDX_W-1:0] read_index();
		int near;
		if ($urandom_range(0, 99) < 60) begin
			near = int'(cursor_now) - int'($urandom_range(1, 200));
			if (near < 0)
				near = 0;
			return IDX_W'(near);
		end
		return IDX_W'($urandom_range(0, 2047));
	endfunction

	// Offer one request and hold it until taken, then maybe drop valid for a
	// while. Always entered at a rising edge and left at one.
	task automatic send_request(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] ch,
			input logic [ATTR_W-1:0] at, input logic [IDX_W-1:0] idx);
		in_valid   <= 1'b1;
		func       <= f;
		char_code  <= ch;
		attribute  <= at;
		cell_index <= idx;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		requests_sent++;
		if ($urandom_range(0, 99) < sender_gap_pct) begin
			in_valid <= 1'b0;
			repeat (idle_length()) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every predicted result has been delivered.
	// The first edge lets the checker's count catch up with the last request.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_blank_attribute(input logic [ATTR_W-1:0] value);
		wait_for_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic directed_requests();
		// reset contents, last cell, and reads past the end of the buffer
		send_request(FUNC_READ, 8'h00, 8'h00, '0);
		send_request(FUNC_READ, 8'hFF, 8'hFF, IDX_W'(DEF_CELLS - 1));
		send_request(FUNC_READ, 8'h00, 8'h00, IDX_W'(DEF_CELLS));
		send_request(FUNC_READ, 8'h00, 8'h00, '1);
		// unused code and backspace in column 0 must leave everything alone
		send_request(FUNC_UNUSED, 8'h41, 8'h1F, IDX_W'(5));
		send_request(FUNC_PUT, CHAR_BS, 8'h00, '0);
		// extremes of character and attribute
		send_request(FUNC_PUT, 8'h00, 8'h00, '0);
		send_request(FUNC_PUT, 8'hFF, 8'hFF, '1);
		send_request(FUNC_PUT, CHAR_BS, 8'h00, '0);
		send_request(FUNC_PUT, 8'h5A, 8'h1E, '0);
		send_request(FUNC_PUT, CHAR_CR, 8'hAA, '0);
		send_request(FUNC_READ, 8'h00, 8'h00, IDX_W'(0));
		send_request(FUNC_READ, 8'h00, 8'h00, IDX_W'(1));
		send_request(FUNC_PUT, CHAR_LF, 8'h55, '0);
		send_request(FUNC_PUT, 8'h7F, 8'h80, '0);
		send_request(FUNC_PUT, CHAR_SPACE, 8'h01, '0);
		send_request(FUNC_READ, 8'h00, 8'h00, IDX_W'(DEF_COLUMNS));
		send_request(FUNC_CLEAR, 8'h00, 8'h00, '0);
		send_request(FUNC_READ, 8'h00, 8'h00, IDX_W'(DEF_COLUMNS));
		send_request(FUNC_UNUSED, 8'hFF, 8'hFF, '1);
	endtask

	// Mostly text lines, newline runs, read-backs and backspaces with random
	// content; clears are rare so the cursor reaches the bottom and scrolls.
	// Runs stop early once the phase budget is spent.
	task automatic run_traffic(input int unsigned budget);
		int unsigned       first;
		int unsigned       pick;
		int unsigned       len;
		int unsigned       k;
		logic [ATTR_W-1:0] line_attr;
		logic [FUNC_W-1:0] f;
		first = requests_sent;
		while (requests_sent - first < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				line_attr = ATTR_W'($urandom_range(0, 255));
				len = ($urandom_range(0, 99) < 15) ? $urandom_range(60, 100)
					: $urandom_range(0, 20);
				for (k = 0; k < len && requests_sent - first < budget; k++)
					send_request(FUNC_PUT, printable_char(), line_attr, IDX_W'($urandom));
				pick = $urandom_range(0, 99);
				if (pick < 70)
					send_request(FUNC_PUT, CHAR_LF, ATTR_W'($urandom), IDX_W'($urandom));
				else if (pick < 90)
					send_request(FUNC_PUT, CHAR_CR, ATTR_W'($urandom), IDX_W'($urandom));
			end else if (pick < 52) begin
				len = $urandom_range(5, 25);
				for (k = 0; k < len && requests_sent - first < budget; k++)
					send_request(FUNC_PUT, CHAR_LF, ATTR_W'($urandom), IDX_W'($urandom));
			end else if (pick < 67) begin
				len = $urandom_range(1, 6);
				for (k = 0; k < len && requests_sent - first < budget; k++)
					send_request(FUNC_READ, CHAR_W'($urandom), ATTR_W'($urandom),
						read_index());
			end else if (pick < 77) begin
				len = $urandom_range(1, 8);
				for (k = 0; k < len && requests_sent - first < budget; k++)
					send_request(FUNC_PUT, CHAR_BS, ATTR_W'($urandom), IDX_W'($urandom));
				len = $urandom_range(0, 3);
				for (k = 0; k < len && requests_sent - first < budget; k++)
					send_request(FUNC_PUT, printable_char(), ATTR_W'($urandom),
						IDX_W'($urandom));
			end else if (pick < 79) begin
				send_request(FUNC_CLEAR, CHAR_W'($urandom), ATTR_W'($urandom),
					IDX_W'($urandom));
			end else begin
				// noise: any code with any payload
				len = $urandom_range(1, 3);
				for (k = 0; k < len && requests_sent - first < budget; k++) begin
					pick = $urandom_range(0, 99);
					f = (pick < 50) ? FUNC_PUT : (pick < 75) ? FUNC_READ
						: (pick < 80) ? FUNC_CLEAR : FUNC_UNUSED;
					send_request(f, CHAR_W'($urandom), ATTR_W'($urandom),
						IDX_W'($urandom_range(0, 2047)));
				end
			end
		end
	endtask

	// Result side: random stalls, plus one long hold-off on demand so the
	// block fills up and has to push back on the request channel.
	initial begin : result_sink
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_results) begin
				hold_results = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 99) < sink_stall_pct) begin
				out_ready <= 1'b0;
				repeat (idle_length()) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Give up if neither channel moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, pending);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [ATTR_W-1:0] attr_c;
		logic [ATTR_W-1:0] attr_d;
		arst_n = 1'b0;
		in_valid   <= 1'b0;
		func       <= FUNC_PUT;
		char_code  <= '0;
		attribute  <= '0;
		cell_index <= '0;
		cfg_we     <= 1'b0;
		cfg_wdata  <= '0;
		attr_c = ATTR_W'($urandom_range(1, 254));
		attr_d = ATTR_W'($urandom_range(1, 254));
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under the reset blank attribute, light throttling
		sender_gap_pct = 20;
		sink_stall_pct = 20;
		directed_requests();

		// all-zero blank attribute, both sides idling often
		set_blank_attribute(8'h00);
		sender_gap_pct = 30;
		sink_stall_pct = 30;
		run_traffic(PHASE_ITEMS);

		// all-ones blank attribute, no idling, and one long hold on results
		// while requests keep coming
		set_blank_attribute(8'hFF);
		sender_gap_pct = 0;
		sink_stall_pct = 0;
		hold_results   = 1'b1;
		run_traffic(PHASE_ITEMS);

		// random attribute; pause mid-phase until every result is back
		set_blank_attribute(attr_c);
		sender_gap_pct = 50;
		sink_stall_pct = 20;
		run_traffic(PHASE_ITEMS / 2);
		wait_for_results();
		run_traffic(PHASE_ITEMS / 2);

		// another random attribute, receiver the slow side
		set_blank_attribute(attr_d);
		sender_gap_pct = 10;
		sink_stall_pct = 60;
		run_traffic(PHASE_ITEMS);

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d requests: %0d reads, %0d scrolls, put/clear/unused codes.",
			requests_seen, reads_seen, scrolls_seen);
		$display("Blank attributes used: 0x%02h, 0x00, 0xFF, 0x%02h, 0x%02h.",
			RESET_ATTR, attr_c, attr_d);
		if (failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== text_console_cursor_engine_unit.f =====
src/tcce_pkg.sv
src/tcce_dp.sv
src/tcce_ctrl.sv
src/text_console_cursor_engine_unit.sv
tb/console_screen_checker.sv
tb/testbench.sv
